// ===== hw/rtl/adbq_pkg.sv =====
// Shared types, codes and helper functions for the ADB input device queues.
// No dependencies; used by adbq_fifo, adb_input_device_queues and the testbench.
`default_nettype none

package adbq_pkg;

    typedef enum logic [2:0] {
        CMD_KEY        = 3'd0,
        CMD_MOUSE      = 3'd1,
        CMD_FORM       = 3'd2,
        CMD_POP_KBD    = 3'd3,
        CMD_POP_MOUSE  = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_GET_HANDLE = 3'd6,
        CMD_SET_HANDLE = 3'd7
    } cmd_t;

    // Control group from the command decoder to one FIFO
    typedef struct packed {
        logic       push;
        logic [1:0] pop;    // entries popped this transfer: 0, 1 or 2
        logic       clear;
    } fifo_ctl_t;

    localparam logic [3:0] ADDR_KBD       = 4'd2;
    localparam logic [3:0] ADDR_MOUSE     = 4'd3;
    localparam logic [7:0] HANDLE_PASS    = 8'hFF;
    localparam logic [7:0] HANDLE_DEFAULT = 8'h01;
    localparam logic [7:0] KEY_PAD        = 8'hFF;

    function automatic logic [7:0] validate_handle(input logic [3:0] addr,
                                                   input logic [7:0] id);
        logic [7:0] res;
        res = id;
        if (id == HANDLE_PASS)
        begin
            res = HANDLE_PASS;
        end
        else if (addr == ADDR_KBD)
        begin
            res = (id == 8'h01 || id == 8'h02 || id == 8'h03) ? id : HANDLE_DEFAULT;
        end
        else if (addr == ADDR_MOUSE)
        begin
            res = (id == 8'h01 || id == 8'h02 || id == 8'h04) ? id : HANDLE_DEFAULT;
        end
        return res;
    endfunction

    // Signed 16-bit add, saturating at the rails
    function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
        logic signed [16:0] s;
        logic signed [15:0] res;
        s = {a[15], a} + {b[15], b};
        if (s[16] != s[15])
        begin
            res = s[16] ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            res = s[15:0];
        end
        return res;
    endfunction

    // Clamp to +/-127, returned as an 8-bit two's complement byte
    function automatic logic [7:0] clamp127(input logic signed [15:0] a);
        logic [7:0] res;
        if (a > 16'sd127)
        begin
            res = 8'h7F;
        end
        else if (a < -16'sd127)
        begin
            res = 8'h81;
        end
        else
        begin
            res = a[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/adb_input_device_queues.sv =====
// Top level of the ADB keyboard/mouse register-0 emulation queues.
// Depends on adbq_pkg and adbq_fifo.
`default_nettype none

// One command enters per transfer on the s_ side and yields exactly one result on the
// m_ side. A command is captured in an input register, decoded against the queue
// state by single-pass logic and written to a result register, so one command per
// clock is sustained while the result side is not stalled; a command reaches m_tvalid
// through the input register and then the result register before it leaves. Each
// FIFO reads its next one or two entries ahead through a registered read port, which
// is what lets a pop or a report pairing finish in the same cycle. A stalled result
// blocks only the command behind it: the input side stays open while the result
// register can be drained in the same cycle. FIFO storage is not cleared at reset
// (only pointers), so no clearing pass is needed. The kbd report FIFO uses KEY_DEPTH.
module adb_input_device_queues #(
    parameter int KEY_DEPTH   = 16,
    parameter int MOUSE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // key_code[6:0], key_down[7], motion_x[23:8], motion_y[39:24],
    // button_bits[47:40], address[51:48], handle_id[59:52], zero[63:60]
    input  wire logic [63:0] s_tdata,
    // cmd[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // ok[0], first_byte[8:1], second_byte[16:9], handle_out[24:17],
    // fail_total[56:25], zero[63:57]
    output logic [63:0]      m_tdata
);

    localparam int KCW = $clog2(KEY_DEPTH + 1);
    localparam int MCW = $clog2(MOUSE_DEPTH + 1);

    // ---------------- input register ----------------
    logic                  in_v_reg;
    adbq_pkg::cmd_t        cmd_reg;
    logic [6:0]            key_code_reg;
    logic                  key_down_reg;
    logic signed [15:0]    motion_x_reg;
    logic signed [15:0]    motion_y_reg;
    logic                  button_reg;      // only bit 0 matters
    logic [3:0]            address_reg;
    logic [7:0]            handle_id_reg;

    // ---------------- device state ----------------
    logic signed [15:0]    accum_x_reg, accum_x_next;
    logic signed [15:0]    accum_y_reg, accum_y_next;
    logic                  button_held_reg, button_held_next;
    logic [31:0]           fail_counter_reg, fail_counter_next;

    // ---------------- result register ----------------
    logic                  out_v_reg;
    logic                  ok_reg, ok_next;
    logic [7:0]            first_reg, first_next;
    logic [7:0]            second_reg, second_next;
    logic [7:0]            handle_reg, handle_next;

    // ---------------- FIFO hookup ----------------
    adbq_pkg::fifo_ctl_t   key_ctl, kbd_ctl, mouse_ctl;
    logic [7:0]            key_push_data;
    logic [15:0]           kbd_push_data, mouse_push_data;
    logic [KCW-1:0]        key_count, kbd_count;
    logic [MCW-1:0]        mouse_count;
    logic [7:0]            key_rd0, key_rd1;
    logic [15:0]           kbd_rd0, mouse_rd0;

    logic                  process;
    logic                  s_xfer;
    logic [1:0]            fail_inc;

    // handshake: process when the result register is free or being drained
    assign process  = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || process;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (s_xfer)
        begin
            in_v_reg <= 1'b1;
        end
        else if (process)
        begin
            in_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            cmd_reg       <= adbq_pkg::cmd_t'(s_tuser);
            key_code_reg  <= s_tdata[6:0];
            key_down_reg  <= s_tdata[7];
            motion_x_reg  <= s_tdata[23:8];
            motion_y_reg  <= s_tdata[39:24];
            button_reg    <= s_tdata[40];
            address_reg   <= s_tdata[51:48];
            handle_id_reg <= s_tdata[59:52];
        end
    end

    // ---------------- command decode ----------------
    always_comb
    begin
        logic [7:0] k2;
        logic [7:0] mfirst;
        logic [7:0] msecond;
        logic       kbd_formed;

        key_ctl           = '0;
        kbd_ctl           = '0;
        mouse_ctl         = '0;
        key_push_data     = {~key_down_reg, key_code_reg};   // bit 7 marks release
        k2                = (key_count >= KCW'(2)) ? key_rd1 : adbq_pkg::KEY_PAD;
        kbd_push_data     = {key_rd0, k2};
        mfirst            = adbq_pkg::clamp127(accum_x_reg);
        mfirst            = {button_held_reg, mfirst[6:0]};
        msecond           = adbq_pkg::clamp127(accum_y_reg);
        mouse_push_data   = {mfirst, msecond};
        kbd_formed        = 1'b0;
        accum_x_next      = accum_x_reg;
        accum_y_next      = accum_y_reg;
        button_held_next  = button_held_reg;
        fail_inc          = 2'd0;
        ok_next           = 1'b0;
        first_next        = 8'h00;
        second_next       = 8'h00;
        handle_next       = 8'h00;

        if (process)
        begin
            case (cmd_reg)
                adbq_pkg::CMD_KEY:
                begin
                    if (key_count != KCW'(KEY_DEPTH))
                    begin
                        key_ctl.push = 1'b1;
                        ok_next      = 1'b1;
                    end
                    else
                    begin
                        fail_inc = 2'd1;
                    end
                end
                adbq_pkg::CMD_MOUSE:
                begin
                    accum_x_next     = adbq_pkg::sat_add16(accum_x_reg, motion_x_reg);
                    accum_y_next     = adbq_pkg::sat_add16(accum_y_reg, motion_y_reg);
                    button_held_next = button_reg;
                    ok_next          = 1'b1;
                end
                adbq_pkg::CMD_FORM:
                begin
                    ok_next = 1'b1;
                    if (key_count != '0)
                    begin
                        // pair up to two codes; a full report queue loses them
                        kbd_formed  = 1'b1;
                        key_ctl.pop = (key_count >= KCW'(2)) ? 2'd2 : 2'd1;
                        first_next  = key_rd0;
                        second_next = k2;
                        if (kbd_count != KCW'(KEY_DEPTH))
                        begin
                            kbd_ctl.push = 1'b1;
                        end
                        else
                        begin
                            fail_inc = fail_inc + 2'd1;
                            ok_next  = 1'b0;
                        end
                    end
                    if (accum_x_reg != '0 || accum_y_reg != '0)
                    begin
                        if (!kbd_formed)
                        begin
                            first_next  = mfirst;
                            second_next = msecond;
                        end
                        if (mouse_count != MCW'(MOUSE_DEPTH))
                        begin
                            mouse_ctl.push = 1'b1;
                            accum_x_next   = '0;
                            accum_y_next   = '0;
                        end
                        else
                        begin
                            fail_inc = fail_inc + 2'd1;
                            ok_next  = 1'b0;
                        end
                    end
                end
                adbq_pkg::CMD_POP_KBD:
                begin
                    if (kbd_count != '0)
                    begin
                        kbd_ctl.pop = 2'd1;
                        ok_next     = 1'b1;
                        first_next  = kbd_rd0[15:8];
                        second_next = kbd_rd0[7:0];
                    end
                end
                adbq_pkg::CMD_POP_MOUSE:
                begin
                    if (mouse_count != '0)
                    begin
                        mouse_ctl.pop = 2'd1;
                        ok_next       = 1'b1;
                        first_next    = mouse_rd0[15:8];
                        second_next   = mouse_rd0[7:0];
                    end
                end
                adbq_pkg::CMD_CLEAR:
                begin
                    if (address_reg == adbq_pkg::ADDR_KBD)
                    begin
                        key_ctl.clear = 1'b1;
                        kbd_ctl.clear = 1'b1;
                        ok_next       = 1'b1;
                    end
                    else if (address_reg == adbq_pkg::ADDR_MOUSE)
                    begin
                        // button state is kept
                        mouse_ctl.clear = 1'b1;
                        accum_x_next    = '0;
                        accum_y_next    = '0;
                        ok_next         = 1'b1;
                    end
                end
                adbq_pkg::CMD_GET_HANDLE:
                begin
                    handle_next = adbq_pkg::validate_handle(address_reg, handle_id_reg);
                    ok_next     = 1'b1;
                end
                adbq_pkg::CMD_SET_HANDLE:
                begin
                    handle_next = adbq_pkg::validate_handle(address_reg, handle_id_reg);
                    ok_next     = (handle_next == handle_id_reg);
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    assign fail_counter_next = fail_counter_reg + 32'(fail_inc);

    // device state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_x_reg      <= '0;
            accum_y_reg      <= '0;
            button_held_reg  <= 1'b0;
            fail_counter_reg <= '0;
            out_v_reg        <= 1'b0;
        end
        else
        begin
            if (process)
            begin
                accum_x_reg      <= accum_x_next;
                accum_y_reg      <= accum_y_next;
                button_held_reg  <= button_held_next;
                fail_counter_reg <= fail_counter_next;
                out_v_reg        <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // result payload; the fail counter only moves together with this register
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            ok_reg     <= ok_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            handle_reg <= handle_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, fail_counter_reg, handle_reg, second_reg, first_reg, ok_reg};

    // ---------------- queues ----------------
    adbq_fifo #(
        .WIDTH (8),
        .DEPTH (KEY_DEPTH)
    ) u_key_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (key_ctl),
        .push_data (key_push_data),
        .count     (key_count),
        .rd0       (key_rd0),
        .rd1       (key_rd1)
    );

    adbq_fifo #(
        .WIDTH (16),
        .DEPTH (KEY_DEPTH)
    ) u_kbd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (kbd_ctl),
        .push_data (kbd_push_data),
        .count     (kbd_count),
        .rd0       (kbd_rd0),
        .rd1       ()
    );

    adbq_fifo #(
        .WIDTH (16),
        .DEPTH (MOUSE_DEPTH)
    ) u_mouse_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mouse_ctl),
        .push_data (mouse_push_data),
        .count     (mouse_count),
        .rd0       (mouse_rd0),
        .rd1       ()
    );

endmodule

`default_nettype wire

// ===== hw/rtl/adbq_fifo.sv =====
// Circular FIFO with pop of up to two entries and registered lookahead reads.
// Depends on adbq_pkg (fifo_ctl_t).
`default_nettype none

module adbq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire adbq_pkg::fifo_ctl_t          ctl,
    input  wire logic [WIDTH-1:0]             push_data,
    output logic [$clog2(DEPTH+1)-1:0]        count,
    output logic [WIDTH-1:0]                  rd0,    // entry at tail
    output logic [WIDTH-1:0]                  rd1     // entry after tail
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    raddr0, raddr1;
    logic [WIDTH-1:0] rd0_reg, rd1_reg;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (ctl.push)
            begin
                head_next = inc(head_reg);
            end
            case (ctl.pop)
                2'd1:    tail_next = inc(tail_reg);
                2'd2:    tail_next = inc(inc(tail_reg));
                default: tail_next = tail_reg;
            endcase
            count_next = count_reg + CW'(ctl.push) - CW'(ctl.pop);
        end
    end

    // lookahead: read where the tail will be after this edge
    assign raddr0 = tail_next;
    assign raddr1 = inc(tail_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage and registered reads, write-through on address match
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[head_reg] <= push_data;
        end
        rd0_reg <= (ctl.push && head_reg == raddr0) ? push_data : mem[raddr0];
        rd1_reg <= (ctl.push && head_reg == raddr1) ? push_data : mem[raddr1];
    end

    assign count = count_reg;
    assign rd0   = rd0_reg;
    assign rd1   = rd1_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/adbq_checker.sv =====
// Port-level checker for adb_input_device_queues, with its bind statement.
// Depends on nothing but the top level's ports.
`default_nettype none

module adbq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    logic        have_prev_reg;
    logic [31:0] prev_fail_reg;
    logic [31:0] fail_step;
    logic        m_xfer;
    logic        s_xfer;

    assign m_xfer    = m_tvalid && m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign fail_step = m_tdata[56:25] - prev_fail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_fail_reg <= '0;
        end
        else if (m_xfer)
        begin
            have_prev_reg <= 1'b1;
            prev_fail_reg <= m_tdata[56:25];
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // draining the result side always frees the input side
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input blocked while result drains");

    // every command is followed by a valid result on the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |-> ##2 m_tvalid)
        else $error("result missing after input transfer");

    // one command rejects at most two pushes
    a_fail_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && have_prev_reg |-> fail_step <= 32'd2)
        else $error("fail counter jumped");

endmodule

bind adb_input_device_queues adbq_checker u_adbq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== sim/adb_input_device_queues_test.sv =====
// Self-checking testbench for adb_input_device_queues (ADB register-0 keyboard/mouse queues).
// Depends on adbq_pkg and the block's RTL; builds its expected results from the directed
// script rows or its own behavioral copy of the queues, accumulators and failure counter.
`timescale 1ns / 100ps

module adb_input_device_queues_test;

    localparam int KEY_DEPTH   = 16;
    localparam int MOUSE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_CMDS = 600;
    localparam int RX_HOLD     = 300;    // long receiver hold-off, in cycles
    localparam int DRAIN_WAIT  = 10;     // idle cycles after the last result drains

    // s_tdata layout, MSB first: pad, handle_id, address, button_bits, motion_y,
    // motion_x, key_down, key_code
    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  handle_id;
        logic [3:0]  address;
        logic [7:0]  buttons;
        logic [15:0] motion_y;
        logic [15:0] motion_x;
        logic        key_down;
        logic [6:0]  key_code;
    } dev_cmd_t;

    // m_tdata layout, MSB first
    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] fail_total;
        logic [7:0]  handle_out;
        logic [7:0]  second_byte;
        logic [7:0]  first_byte;
        logic        ok;
    } dev_result_t;

    typedef struct {
        adbq_pkg::cmd_t cmd;
        dev_cmd_t       fields;
        bit             typed;    // expected result written into the row
        dev_result_t    want;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    // Typed expectation travelling alongside the command being offered
    bit          cur_typed;
    dev_result_t cur_want;

    // Shadow copy of the block's state
    logic [7:0]  key_codes_q[$];
    logic [15:0] kbd_reports_q[$];
    logic [15:0] mouse_reports_q[$];
    int          motion_acc_x;
    int          motion_acc_y;
    logic        button_held;
    logic [31:0] push_rejects;

    dev_result_t pending_results_q[$];
    script_row_t script_rows[$];

    bit          quiet;          // no idling on either side
    int          rx_hold_left;   // set by the stimulus, counted down by the receiver
    int          mismatches;
    int          results_seen;
    int          cmd_seen[8];
    int          cycle_count;

    adb_input_device_queues #(
        .KEY_DEPTH   (KEY_DEPTH),
        .MOUSE_DEPTH (MOUSE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results_q.size());
            $display("FAIL adb_input_device_queues");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Behavioral copy of the block
    // ------------------------------------------------------------------
    function automatic int saturate16(int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    // Mouse report motion byte: clamped to +/-127, two's complement
    function automatic logic [7:0] motion_byte(int v);
        int c;
        c = (v > 127) ? 127 : ((v < -127) ? -127 : v);
        return c[7:0];
    endfunction

    function automatic logic [7:0] checked_handle(logic [3:0] addr, logic [7:0] id);
        if (id == adbq_pkg::HANDLE_PASS)
        begin
            return adbq_pkg::HANDLE_PASS;
        end
        if (addr == adbq_pkg::ADDR_KBD)
        begin
            return (id >= 8'd1 && id <= 8'd3) ? id : adbq_pkg::HANDLE_DEFAULT;
        end
        if (addr == adbq_pkg::ADDR_MOUSE)
        begin
            return (id == 8'd1 || id == 8'd2 || id == 8'd4) ? id : adbq_pkg::HANDLE_DEFAULT;
        end
        return id;
    endfunction

    // Applies one command to the shadow state and returns the result it must produce
    function automatic dev_result_t device_step(adbq_pkg::cmd_t cmd, dev_cmd_t f);
        dev_result_t r;
        logic [7:0]  k1;
        logic [7:0]  k2;
        logic [7:0]  mb1;
        logic [7:0]  mb2;
        logic [15:0] rep;
        bit          kbd_formed;
        r = '0;
        case (cmd)
            adbq_pkg::CMD_KEY:
            begin
                if (key_codes_q.size() < KEY_DEPTH)
                begin
                    key_codes_q.push_back({~f.key_down, f.key_code});
                    r.ok = 1'b1;
                end
                else
                begin
                    push_rejects++;
                end
            end
            adbq_pkg::CMD_MOUSE:
            begin
                motion_acc_x = saturate16(motion_acc_x + int'($signed(f.motion_x)));
                motion_acc_y = saturate16(motion_acc_y + int'($signed(f.motion_y)));
                button_held  = f.buttons[0];
                r.ok = 1'b1;
            end
            adbq_pkg::CMD_FORM:
            begin
                r.ok = 1'b1;
                kbd_formed = 1'b0;
                if (key_codes_q.size() != 0)
                begin
                    k1 = key_codes_q.pop_front();
                    k2 = (key_codes_q.size() != 0) ? key_codes_q.pop_front()
                                                   : adbq_pkg::KEY_PAD;
                    kbd_formed = 1'b1;
                    r.first_byte  = k1;
                    r.second_byte = k2;
                    // a rejected report loses the codes it popped
                    if (kbd_reports_q.size() < KEY_DEPTH)
                    begin
                        kbd_reports_q.push_back({k1, k2});
                    end
                    else
                    begin
                        push_rejects++;
                        r.ok = 1'b0;
                    end
                end
                if (motion_acc_x != 0 || motion_acc_y != 0)
                begin
                    mb1 = motion_byte(motion_acc_x);
                    mb1 = {button_held, mb1[6:0]};
                    mb2 = motion_byte(motion_acc_y);
                    if (!kbd_formed)
                    begin
                        r.first_byte  = mb1;
                        r.second_byte = mb2;
                    end
                    // motion is kept for the next try when the report is rejected
                    if (mouse_reports_q.size() < MOUSE_DEPTH)
                    begin
                        mouse_reports_q.push_back({mb1, mb2});
                        motion_acc_x = 0;
                        motion_acc_y = 0;
                    end
                    else
                    begin
                        push_rejects++;
                        r.ok = 1'b0;
                    end
                end
            end
            adbq_pkg::CMD_POP_KBD:
            begin
                if (kbd_reports_q.size() != 0)
                begin
                    rep = kbd_reports_q.pop_front();
                    r.ok = 1'b1;
                    {r.first_byte, r.second_byte} = rep;
                end
            end
            adbq_pkg::CMD_POP_MOUSE:
            begin
                if (mouse_reports_q.size() != 0)
                begin
                    rep = mouse_reports_q.pop_front();
                    r.ok = 1'b1;
                    {r.first_byte, r.second_byte} = rep;
                end
            end
            adbq_pkg::CMD_CLEAR:
            begin
                if (f.address == adbq_pkg::ADDR_KBD)
                begin
                    key_codes_q.delete();
                    kbd_reports_q.delete();
                    r.ok = 1'b1;
                end
                else if (f.address == adbq_pkg::ADDR_MOUSE)
                begin
                    // button state survives a mouse clear
                    mouse_reports_q.delete();
                    motion_acc_x = 0;
                    motion_acc_y = 0;
                    r.ok = 1'b1;
                end
            end
            adbq_pkg::CMD_GET_HANDLE:
            begin
                r.handle_out = checked_handle(f.address, f.handle_id);
                r.ok = 1'b1;
            end
            default:
            begin
                r.handle_out = checked_handle(f.address, f.handle_id);
                r.ok = (r.handle_out == f.handle_id);
            end
        endcase
        r.fail_total = push_rejects;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Transfer monitor: predicts on input transfers, checks output transfers
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        dev_result_t got;
        dev_result_t exp_r;
        dev_result_t pred;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = dev_result_t'(m_tdata);
                results_seen++;
                if (pending_results_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: result with nothing expected: %h", $realtime, m_tdata);
                    end
                end
                else
                begin
                    exp_r = pending_results_q.pop_front();
                    if (got.ok !== exp_r.ok || got.first_byte !== exp_r.first_byte
                        || got.second_byte !== exp_r.second_byte
                        || got.handle_out !== exp_r.handle_out
                        || got.fail_total !== exp_r.fail_total || got.pad !== '0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result %0d mismatch", $realtime, results_seen);
                            $display("  exp ok=%0d b1=%h b2=%h hnd=%h fails=%0d",
                                     exp_r.ok, exp_r.first_byte, exp_r.second_byte,
                                     exp_r.handle_out, exp_r.fail_total);
                            $display("  got ok=%0d b1=%h b2=%h hnd=%h fails=%0d pad=%h",
                                     got.ok, got.first_byte, got.second_byte,
                                     got.handle_out, got.fail_total, got.pad);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                cmd_seen[s_tuser]++;
                pred = device_step(adbq_pkg::cmd_t'(s_tuser), dev_cmd_t'(s_tdata));
                pending_results_q.push_back(cur_typed ? cur_want : pred);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                m_tready <= quiet || ($urandom_range(99) >= 11);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Offers one command and returns on the edge of its transfer, tvalid left high
    task automatic send_cmd(adbq_pkg::cmd_t cmd, dev_cmd_t f, bit typed, dev_result_t want);
        int gap;
        gap = (!quiet && $urandom_range(99) < 11) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= cmd;
        s_tdata   <= f;
        cur_typed <= typed;
        cur_want  <= want;
        // ready is stable from the falling edge up to the transfer edge
        @(negedge clk);
        while (!s_tready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    function automatic void add_row(adbq_pkg::cmd_t cmd, int code, bit down, int mx, int my,
                                    int btn, int addr, int hid, bit typed,
                                    bit ok, int b1, int b2, int hout);
        script_row_t row;
        row.cmd    = cmd;
        row.fields = '0;
        row.fields.key_code  = 7'(code);
        row.fields.key_down  = down;
        row.fields.motion_x  = 16'(mx);
        row.fields.motion_y  = 16'(my);
        row.fields.buttons   = 8'(btn);
        row.fields.address   = 4'(addr);
        row.fields.handle_id = 8'(hid);
        row.typed = typed;
        row.want  = '0;
        row.want.ok          = ok;
        row.want.first_byte  = 8'(b1);
        row.want.second_byte = 8'(b2);
        row.want.handle_out  = 8'(hout);
        script_rows.push_back(row);
    endfunction

    // Motion deltas: small, moderate, the rails or anything, each equally likely
    function automatic logic [15:0] pick_delta();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(20)) - 10);
            2:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'(int'($urandom_range(600)) - 300);
        endcase
    endfunction

    // mode 0 mixed traffic, 1 mostly producers (fills the queues), 2 mostly consumers
    function automatic adbq_pkg::cmd_t pick_cmd(int mode);
        int w;
        w = $urandom_range(99);
        case (mode)
            1:
            begin
                if (w < 45) return adbq_pkg::CMD_KEY;
                if (w < 68) return adbq_pkg::CMD_MOUSE;
                if (w < 93) return adbq_pkg::CMD_FORM;
                if (w < 96) return adbq_pkg::CMD_GET_HANDLE;
                return adbq_pkg::CMD_SET_HANDLE;
            end
            2:
            begin
                if (w < 30) return adbq_pkg::CMD_POP_KBD;
                if (w < 60) return adbq_pkg::CMD_POP_MOUSE;
                if (w < 82) return adbq_pkg::CMD_FORM;
                if (w < 92) return adbq_pkg::CMD_KEY;
                if (w < 96) return adbq_pkg::CMD_MOUSE;
                return adbq_pkg::CMD_CLEAR;
            end
            default:
            begin
                if (w < 25) return adbq_pkg::CMD_KEY;
                if (w < 40) return adbq_pkg::CMD_MOUSE;
                if (w < 60) return adbq_pkg::CMD_FORM;
                if (w < 72) return adbq_pkg::CMD_POP_KBD;
                if (w < 84) return adbq_pkg::CMD_POP_MOUSE;
                if (w < 88) return adbq_pkg::CMD_CLEAR;
                if (w < 94) return adbq_pkg::CMD_GET_HANDLE;
                return adbq_pkg::CMD_SET_HANDLE;
            end
        endcase
    endfunction

    initial
    begin
        dev_cmd_t    f;
        dev_result_t none;
        int          mode;

        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = adbq_pkg::CMD_KEY;
        m_tready     = 1'b0;
        cur_typed    = 1'b0;
        cur_want     = '0;
        quiet        = 1'b0;
        rx_hold_left = 0;
        mismatches   = 0;
        results_seen = 0;
        cycle_count  = 0;
        motion_acc_x = 0;
        motion_acc_y = 0;
        button_held  = 1'b0;
        push_rejects = '0;
        none         = '0;
        foreach (cmd_seen[i])
        begin
            cmd_seen[i] = 0;
        end

        // Directed script: empty pops, key pairing with padding, motion rails and
        // clamping, button bit, handle validation per address, per-address clears.
        //      cmd                       code dn mx     my      btn  adr hid  ty ok b1   b2   hnd
        add_row(adbq_pkg::CMD_POP_KBD,    0,   0, 0,     0,      0,   0,  0,   1, 0, 0,   0,   0);
        add_row(adbq_pkg::CMD_POP_MOUSE,  0,   0, 0,     0,      0,   0,  0,   1, 0, 0,   0,   0);
        add_row(adbq_pkg::CMD_FORM,       0,   0, 0,     0,      0,   0,  0,   1, 1, 0,   0,   0);
        add_row(adbq_pkg::CMD_KEY,        127, 1, 0,     0,      0,   0,  0,   0, 0, 0,   0,   0);
        add_row(adbq_pkg::CMD_KEY,        0,   0, 0,     0,      0,   0,  0,   0, 0, 0,   0,   0);
        add_row(adbq_pkg::CMD_KEY,        'h55,0, 0,     0,      0,   0,  0,   0, 0, 0,   0,   0);
        add_row(adbq_pkg::CMD_FORM,       0,   0, 0,     0,      0,   0,  0,   1, 1, 'h7F,'h80,0);
        add_row(adbq_pkg::CMD_FORM,       0,   0, 0,     0,      0,   0,  0,   1, 1, 'hD5,'hFF,0);
        add_row(adbq_pkg::CMD_POP_KBD,    0,   0, 0,     0,      0,   0,  0,   1, 1, 'h7F,'h80,0);
        add_row(adbq_pkg::CMD_MOUSE,      0,   0, 32767, -32768, 255, 0,  0,   0, 0, 0,   0,   0);
        add_row(adbq_pkg::CMD_MOUSE,      0,   0, 32767, -32768, 'hFE,0,  0,   0, 0, 0,   0,   0);
        add_row(adbq_pkg::CMD_FORM,       0,   0, 0,     0,      0,   0,  0,   1, 1, 'h7F,'h81,0);
        add_row(adbq_pkg::CMD_POP_MOUSE,  0,   0, 0,     0,      0,   0,  0,   1, 1, 'h7F,'h81,0);
        add_row(adbq_pkg::CMD_MOUSE,      0,   0, -1,    1,      1,   15, 255, 0, 0, 0,   0,   0);
        add_row(adbq_pkg::CMD_FORM,       0,   0, 0,     0,      0,   0,  0,   1, 1, 'hFF,'h01,0);
        add_row(adbq_pkg::CMD_GET_HANDLE, 0,   0, 0,     0,      0,   2,  0,   1, 1, 0,   0,   1);
        add_row(adbq_pkg::CMD_SET_HANDLE, 0,   0, 0,     0,      0,   2,  3,   1, 1, 0,   0,   3);
        add_row(adbq_pkg::CMD_SET_HANDLE, 0,   0, 0,     0,      0,   3,  3,   1, 0, 0,   0,   1);
        add_row(adbq_pkg::CMD_SET_HANDLE, 0,   0, 0,     0,      0,   3,  4,   1, 1, 0,   0,   4);
        add_row(adbq_pkg::CMD_GET_HANDLE, 0,   0, 0,     0,      0,   15, 255, 1, 1, 0,   0,   255);
        add_row(adbq_pkg::CMD_SET_HANDLE, 0,   0, 0,     0,      0,   0,  'h80,1, 1, 0,   0,   'h80);
        add_row(adbq_pkg::CMD_CLEAR,      0,   0, 0,     0,      0,   3,  0,   1, 1, 0,   0,   0);
        add_row(adbq_pkg::CMD_CLEAR,      0,   0, 0,     0,      0,   2,  0,   1, 1, 0,   0,   0);
        add_row(adbq_pkg::CMD_CLEAR,      0,   0, 0,     0,      0,   7,  0,   1, 0, 0,   0,   0);
        add_row(adbq_pkg::CMD_POP_MOUSE,  0,   0, 0,     0,      0,   0,  0,   1, 0, 0,   0,   0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script_rows[i])
        begin
            send_cmd(script_rows[i].cmd, script_rows[i].fields, script_rows[i].typed,
                     script_rows[i].want);
        end

        // Sender pause: let every outstanding result drain
        s_tvalid <= 1'b0;
        while (pending_results_q.size() != 0)
        begin
            @(posedge clk);
        end

        // Random traffic in phases of 50 commands; a no-idle stretch in the middle
        // and one long receiver hold-off while commands keep coming
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            mode  = (n / 50) % 3;
            quiet = (n >= 200 && n < 320);
            if (n == 400)
            begin
                rx_hold_left = RX_HOLD;
            end
            f           = dev_cmd_t'({$urandom, $urandom});
            f.pad       = '0;
            f.motion_x  = pick_delta();
            f.motion_y  = pick_delta();
            f.address   = ($urandom_range(3) == 0) ? 4'($urandom) :
                          ($urandom_range(1) ? adbq_pkg::ADDR_KBD : adbq_pkg::ADDR_MOUSE);
            f.handle_id = $urandom_range(1) ? 8'($urandom_range(5)) : 8'($urandom);
            send_cmd(pick_cmd(mode), f, 1'b0, none);
        end
        quiet    = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d results: key %0d, mouse %0d, form %0d, pops %0d/%0d,",
                 results_seen, cmd_seen[adbq_pkg::CMD_KEY], cmd_seen[adbq_pkg::CMD_MOUSE],
                 cmd_seen[adbq_pkg::CMD_FORM], cmd_seen[adbq_pkg::CMD_POP_KBD],
                 cmd_seen[adbq_pkg::CMD_POP_MOUSE]);
        $display("clear %0d, handle get/set %0d/%0d; %0d rejected pushes; %0d mismatches",
                 cmd_seen[adbq_pkg::CMD_CLEAR], cmd_seen[adbq_pkg::CMD_GET_HANDLE],
                 cmd_seen[adbq_pkg::CMD_SET_HANDLE], push_rejects, mismatches);
        if (mismatches == 0)
        begin
            $display("PASS adb_input_device_queues");
        end
        else
        begin
            $display("FAIL adb_input_device_queues");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/adbq_pkg.sv
hw/rtl/adbq_fifo.sv
hw/rtl/adb_input_device_queues.sv
hw/rtl/adbq_checker.sv
sim/adb_input_device_queues_test.sv
